>>> rtl/rcfd_pkg.sv
package rcfd_pkg;

   localparam int FRAME_LEN         = 18;
   localparam int BYTE_COUNT_W      = 5;
   localparam int STICK_W           = 11;
   localparam int TICK_W            = 8;
   localparam int CSR_DATA_W        = 11;
   localparam int CSR_INDEX_W       = 2;
   localparam int JOB_DEPTH_DEFAULT = 2;

   localparam logic [STICK_W-1:0] STICK_DEFAULT  = 11'd1024;
   // Left switch 1 in bits 3:2, right switch 3 in bits 1:0.
   localparam logic [3:0]         SWITCH_DEFAULT = 4'b0111;

   typedef enum logic [1:0] {
      OP_BYTE = 2'd0,
      OP_EOF  = 2'd1,
      OP_TICK = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_RANGE   = 2'd1,
      STATUS_TIMEOUT = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STICK_MIN = 2'd0,
      CSR_STICK_MAX = 2'd1,
      CSR_TIMEOUT   = 2'd2
   } csr_index_type;

   typedef enum logic {
      JOB_FRAME   = 1'b0,
      JOB_TIMEOUT = 1'b1
   } job_kind_type;

   typedef struct packed {
      job_kind_type                  kind;
      logic [FRAME_LEN-1:0][7:0]     bytes;
   } job_type;

   typedef struct packed {
      logic [STICK_W-1:0] right_x;
      logic [STICK_W-1:0] right_y;
      logic [STICK_W-1:0] left_x;
      logic [STICK_W-1:0] left_y;
      logic [3:0]         switches;
      logic [15:0]        mouse_x;
      logic [15:0]        mouse_y;
      logic [15:0]        mouse_z;
      logic [15:0]        mouse_buttons;
      logic [15:0]        key_mask;
      logic [15:0]        wheel;
      status_type         status;
   } result_type;

endpackage

>>> rtl/rcfd_front.sv
module rcfd_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [1:0]                      req_op,
   input  logic [7:0]                      req_data_byte,
   input  logic [rcfd_pkg::TICK_W-1:0]     timeout_ticks,
   output logic                            job_valid,
   input  logic                            job_ready,
   output rcfd_pkg::job_type               job
);
   import rcfd_pkg::*;

   logic [FRAME_LEN-1:0][7:0]  store_ff, store_in;
   logic [BYTE_COUNT_W-1:0]    count_ff, count_in;
   logic [TICK_W-1:0]          idle_ff, idle_in;
   logic [TICK_W-1:0]          tick_next;
   logic                       accept;

   assign req_full = !job_ready;
   assign accept   = req_push && job_ready;

   // Silence counter saturates so a timeout of 255 never fires.
   assign tick_next = (idle_ff == '1) ? idle_ff : idle_ff + TICK_W'(1);

   always_comb begin
      store_in   = store_ff;
      count_in   = count_ff;
      idle_in    = idle_ff;
      job_valid  = 1'b0;
      job.kind   = JOB_FRAME;
      job.bytes  = store_ff;
      if (accept) begin
         unique case (op_type'(req_op))
            OP_BYTE: begin
               if (count_ff < BYTE_COUNT_W'(FRAME_LEN)) begin
                  store_in[count_ff] = req_data_byte;
                  count_in           = count_ff + BYTE_COUNT_W'(1);
               end
            end
            OP_EOF: begin
               job_valid = 1'b1;
               store_in  = '0;
               count_in  = '0;
               idle_in   = '0;
            end
            OP_TICK: begin
               if (tick_next > timeout_ticks) begin
                  job_valid = 1'b1;
                  job.kind  = JOB_TIMEOUT;
                  idle_in   = '0;
               end else begin
                  idle_in = tick_next;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
         count_ff <= '0;
         idle_ff  <= '0;
      end else begin
         store_ff <= store_in;
         count_ff <= count_in;
         idle_ff  <= idle_in;
      end
   end

endmodule

>>> rtl/rcfd_job_queue.sv
module rcfd_job_queue #(
   parameter int DEPTH = rcfd_pkg::JOB_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rcfd_pkg::job_type   in_job,
   output logic                out_valid,
   input  logic                out_ready,
   output rcfd_pkg::job_type   out_job
);
   import rcfd_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         mem [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign in_ready  = (count_ff != CW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_job   = mem[rd_ptr_ff];
   assign do_push   = in_valid && in_ready;
   assign do_pop    = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= in_job;
      end
   end

endmodule

>>> rtl/rcfd_back.sv
module rcfd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            job_valid,
   output logic                            job_ready,
   input  rcfd_pkg::job_type               job,
   input  logic [rcfd_pkg::STICK_W-1:0]    stick_min,
   input  logic [rcfd_pkg::STICK_W-1:0]    stick_max,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output rcfd_pkg::result_type            result
);
   import rcfd_pkg::*;

   logic [FRAME_LEN-1:0][7:0] b;
   logic [STICK_W-1:0]        rx, ry, lx, ly;
   logic [1:0]                rs, ls;
   logic                      bad;
   result_type                decoded;
   result_type                result_ff;
   logic                      valid_ff, valid_in;

   function automatic logic out_of_range(input logic [STICK_W-1:0] v,
                                         input logic [STICK_W-1:0] lo,
                                         input logic [STICK_W-1:0] hi);
      return (v > hi) || (v < lo);
   endfunction

   assign b  = job.bytes;
   assign rx = {b[1][2:0], b[0]};
   assign ry = {b[2][5:0], b[1][7:3]};
   assign lx = {b[4][0], b[3], b[2][7:6]};
   assign ly = {b[5][3:0], b[4][7:1]};
   assign rs = b[5][5:4];
   assign ls = b[5][7:6];

   assign bad = out_of_range(rx, stick_min, stick_max) ||
                out_of_range(ry, stick_min, stick_max) ||
                out_of_range(lx, stick_min, stick_max) ||
                out_of_range(ly, stick_min, stick_max) ||
                (rs == 2'd0) || (ls == 2'd0);

   always_comb begin
      decoded.right_x       = STICK_DEFAULT;
      decoded.right_y       = STICK_DEFAULT;
      decoded.left_x        = STICK_DEFAULT;
      decoded.left_y        = STICK_DEFAULT;
      decoded.switches      = SWITCH_DEFAULT;
      decoded.mouse_x       = '0;
      decoded.mouse_y       = '0;
      decoded.mouse_z       = '0;
      decoded.mouse_buttons = '0;
      decoded.key_mask      = '0;
      decoded.wheel         = '0;
      decoded.status        = STATUS_TIMEOUT;
      if (job.kind == JOB_FRAME) begin
         if (bad) begin
            decoded.status = STATUS_RANGE;
         end else begin
            decoded.right_x       = rx;
            decoded.right_y       = ry;
            decoded.left_x        = lx;
            decoded.left_y        = ly;
            decoded.switches      = {ls, rs};
            decoded.mouse_x       = {b[7], b[6]};
            decoded.mouse_y       = {b[9], b[8]};
            decoded.mouse_z       = {b[11], b[10]};
            decoded.mouse_buttons = {b[13], b[12]};
            decoded.key_mask      = {b[15], b[14]};
            decoded.wheel         = {b[17], b[16]};
            decoded.status        = STATUS_OK;
         end
      end
   end

   // The output register refills in the same cycle that it is popped.
   assign job_ready = !valid_ff || rsp_pop;
   assign rsp_empty = !valid_ff;
   assign result    = result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (job_valid && job_ready) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_valid && job_ready) begin
         result_ff <= decoded;
      end
   end

endmodule

>>> rtl/rc_frame_decoder_with_watchdog.sv
// Remote-control frame decoder with a link watchdog.
// Input items arrive on a queue-style port: an item is taken at a clock edge
// with req_push high and req_full low. An item is either one received byte,
// an end-of-frame (line idle) marker, or one timer tick. Bytes collect in an
// 18-byte frame store; an end-of-frame item unpacks the store into sticks,
// switches, mouse axes, buttons, key mask and wheel word, or into the default
// values with status 1 if a stick is outside the configured range or a switch
// is zero. Ticks count link silence; once the count exceeds timeout_ticks an
// item of defaults with status 2 is produced.
// Results leave through a queue-style port: the oldest result is on the rsp_
// ports while rsp_empty is low and is taken with rsp_pop.
// The front stage takes one item per cycle while req_full is low. The job
// that an item makes passes through the job queue and then through the
// decode and compare stage that loads the output register.
// If the receiver stalls, the output register and the job queue fill, and
// req_full rises once the queue holds JOB_DEPTH jobs; while rsp_pop is high
// the output register is reloaded every cycle, so the rate stays one item
// per cycle. Reset empties both queues, clears the frame store, the byte count
// and the silence counter, and restores the registers to 364, 1684 and 20.
// Configuration is written through csr_we, csr_index and csr_wdata while idle.
module rc_frame_decoder_with_watchdog #(
   parameter int JOB_DEPTH = rcfd_pkg::JOB_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [1:0]                          req_op,
   input  logic [7:0]                          req_data_byte,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [rcfd_pkg::STICK_W-1:0]        rsp_right_x,
   output logic [rcfd_pkg::STICK_W-1:0]        rsp_right_y,
   output logic [rcfd_pkg::STICK_W-1:0]        rsp_left_x,
   output logic [rcfd_pkg::STICK_W-1:0]        rsp_left_y,
   output logic [3:0]                          rsp_switches,
   output logic signed [15:0]                  rsp_mouse_x,
   output logic signed [15:0]                  rsp_mouse_y,
   output logic signed [15:0]                  rsp_mouse_z,
   output logic [15:0]                         rsp_mouse_buttons,
   output logic [15:0]                         rsp_key_mask,
   output logic [15:0]                         rsp_wheel,
   output logic [1:0]                          rsp_status,
   input  logic                                csr_we,
   input  logic [rcfd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rcfd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rcfd_pkg::*;

   logic [STICK_W-1:0] stick_min_ff;
   logic [STICK_W-1:0] stick_max_ff;
   logic [TICK_W-1:0]  timeout_ff;

   logic       front_valid, front_ready;
   job_type    front_job;
   logic       back_valid, back_ready;
   job_type    back_job;
   result_type result;

   // Configuration registers. Writes to an unused index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         stick_min_ff <= STICK_W'(364);
         stick_max_ff <= STICK_W'(1684);
         timeout_ff   <= TICK_W'(20);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_STICK_MIN: stick_min_ff <= csr_wdata[STICK_W-1:0];
            CSR_STICK_MAX: stick_max_ff <= csr_wdata[STICK_W-1:0];
            CSR_TIMEOUT:   timeout_ff   <= csr_wdata[TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Front: collects bytes, runs the watchdog and issues decode jobs.
   rcfd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .timeout_ticks (timeout_ff),
      .job_valid     (front_valid),
      .job_ready     (front_ready),
      .job           (front_job)
   );

   // Short queue that lets the front keep taking items while the back waits.
   rcfd_job_queue #(
      .DEPTH (JOB_DEPTH)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_job    (front_job),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_job   (back_job)
   );

   // Back: unpacks the frame, checks ranges and holds the result.
   rcfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (back_valid),
      .job_ready (back_ready),
      .job       (back_job),
      .stick_min (stick_min_ff),
      .stick_max (stick_max_ff),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .result    (result)
   );

   assign rsp_right_x       = result.right_x;
   assign rsp_right_y       = result.right_y;
   assign rsp_left_x        = result.left_x;
   assign rsp_left_y        = result.left_y;
   assign rsp_switches      = result.switches;
   assign rsp_mouse_x       = $signed(result.mouse_x);
   assign rsp_mouse_y       = $signed(result.mouse_y);
   assign rsp_mouse_z       = $signed(result.mouse_z);
   assign rsp_mouse_buttons = result.mouse_buttons;
   assign rsp_key_mask      = result.key_mask;
   assign rsp_wheel         = result.wheel;
   assign rsp_status        = result.status;

endmodule
